[rtl/core/urtb_pkg.sv]
`timescale 1ns / 1ps

package urtb_pkg;

    // slots per ring; the send ring always leaves one of them free
    localparam int DEPTH   = 512;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int CNT_W   = 9;
    localparam int FILL_W  = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_kind KIND_RX_BYTE  = 3'd0;
    localparam t_kind KIND_TX_READY = 3'd1;
    localparam t_kind KIND_SW_READ  = 3'd2;
    localparam t_kind KIND_SW_WRITE = 3'd3;
    localparam t_kind KIND_RX_FLUSH = 3'd4;

    localparam t_ptr PTR_LAST = t_ptr'(DEPTH - 1);

endpackage

[rtl/core/uart_rx_tx_ring_buffers_core.sv]
`timescale 1ns / 1ps
// Receive and send byte rings between a serial port and software.
// The result of an item is shown in the cycle after it is accepted.
// Throughput: one item per cycle while the output is not stalled; the registered read port of each ring
// memory holds the popped byte beside the result register.
// Reset (synchronous, active low) clears pointers, flags and the result
// valid; ring memory contents are not cleared and need no clearing pass.

module uart_rx_tx_ring_buffers_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  urtb_pkg::t_kind        i_kind,
    input  urtb_pkg::t_byte        i_data_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output urtb_pkg::t_byte        o_data_out,
    output logic                   o_data_valid,
    output logic                   o_write_accepted,
    output urtb_pkg::t_cnt         o_rx_count,
    output urtb_pkg::t_cnt         o_tx_count,
    output logic                   o_rx_overflow,
    output logic                   o_tx_overflow,
    output logic                   o_tx_irq_enable
);

    function automatic urtb_pkg::t_ptr next_slot(input urtb_pkg::t_ptr p);
        next_slot = (p == urtb_pkg::PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic urtb_pkg::t_cnt fill(input urtb_pkg::t_ptr head,
                                            input urtb_pkg::t_ptr tail);
        urtb_pkg::t_ptr                  f;
        logic [urtb_pkg::FILL_W-1:0]     w;
        if (tail <= head) begin
            f = head - tail;
        end else begin
            f = urtb_pkg::t_ptr'(urtb_pkg::DEPTH) - tail + head;
        end
        w    = urtb_pkg::FILL_W'(f);
        fill = w[urtb_pkg::CNT_W-1:0];
    endfunction

    urtb_pkg::t_ptr r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    urtb_pkg::t_ptr r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic           r_rx_ovf, n_rx_ovf, r_tx_ovf, n_tx_ovf, r_irq, n_irq;
    logic           r_valid, r_dval, n_dval, r_src_tx, n_src_tx, r_wacc, n_wacc;

    logic           in_acc;
    logic           rx_we, rx_re, tx_we, tx_re;
    logic           rx_empty, tx_empty, tx_full;
    urtb_pkg::t_byte rx_q, tx_q;

    assign o_stall  = r_valid & i_stall;
    assign in_acc   = i_valid & ~o_stall;

    assign rx_empty = (r_rx_head == r_rx_tail);
    assign tx_empty = (r_tx_head == r_tx_tail);
    assign tx_full  = (next_slot(r_tx_head) == r_tx_tail);

    always_comb begin
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        n_rx_ovf  = r_rx_ovf;
        n_tx_ovf  = r_tx_ovf;
        n_irq     = r_irq;
        n_dval    = 1'b0;
        n_src_tx  = 1'b0;
        n_wacc    = 1'b0;
        rx_we     = 1'b0;
        rx_re     = 1'b0;
        tx_we     = 1'b0;
        tx_re     = 1'b0;
        if (in_acc) begin
            unique case (i_kind)
                urtb_pkg::KIND_RX_BYTE: begin
                    // store always; meeting the tail means overrun
                    rx_we     = 1'b1;
                    n_rx_head = next_slot(r_rx_head);
                    if (next_slot(r_rx_head) == r_rx_tail) begin
                        n_rx_ovf = 1'b1;
                    end
                end
                urtb_pkg::KIND_TX_READY: begin
                    if (!tx_empty) begin
                        tx_re     = 1'b1;
                        n_dval    = 1'b1;
                        n_src_tx  = 1'b1;
                        n_tx_tail = next_slot(r_tx_tail);
                    end else begin
                        n_irq = 1'b0;
                    end
                end
                urtb_pkg::KIND_SW_READ: begin
                    if (!rx_empty) begin
                        rx_re     = 1'b1;
                        n_dval    = 1'b1;
                        n_rx_tail = next_slot(r_rx_tail);
                    end
                end
                urtb_pkg::KIND_SW_WRITE: begin
                    if (tx_full) begin
                        n_tx_ovf = 1'b1;
                    end else begin
                        tx_we     = 1'b1;
                        n_wacc    = 1'b1;
                        n_tx_head = next_slot(r_tx_head);
                    end
                    n_irq = 1'b1;
                end
                urtb_pkg::KIND_RX_FLUSH: begin
                    n_rx_head = '0;
                    n_rx_tail = '0;
                end
                default: begin
                    // unknown kind: report state only
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_rx_ovf  <= 1'b0;
            r_tx_ovf  <= 1'b0;
            r_irq     <= 1'b0;
            r_valid   <= 1'b0;
            r_dval    <= 1'b0;
            r_src_tx  <= 1'b0;
            r_wacc    <= 1'b0;
        end else begin
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_rx_ovf  <= n_rx_ovf;
            r_tx_ovf  <= n_tx_ovf;
            r_irq     <= n_irq;
            if (in_acc) begin
                r_valid  <= 1'b1;
                r_dval   <= n_dval;
                r_src_tx <= n_src_tx;
                r_wacc   <= n_wacc;
            end else if (!i_stall) begin
                r_valid  <= 1'b0;
            end
        end
    end

    urtb_ram #(
        .WIDTH (urtb_pkg::BYTE_W),
        .DEPTH (urtb_pkg::DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (i_data_in),
        .i_re    (rx_re),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_q)
    );

    urtb_ram #(
        .WIDTH (urtb_pkg::BYTE_W),
        .DEPTH (urtb_pkg::DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (i_data_in),
        .i_re    (tx_re),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_q)
    );

    // state only moves on accept, so it still matches the shown item
    assign o_valid          = r_valid;
    assign o_data_out       = r_dval ? (r_src_tx ? tx_q : rx_q) : '0;
    assign o_data_valid     = r_dval;
    assign o_write_accepted = r_wacc;
    assign o_rx_count       = fill(r_rx_head, r_rx_tail);
    assign o_tx_count       = fill(r_tx_head, r_tx_tail);
    assign o_rx_overflow    = r_rx_ovf;
    assign o_tx_overflow    = r_tx_ovf;
    assign o_tx_irq_enable  = r_irq;

    a_no_pop_and_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_dval && r_wacc))
        else $error("pop and queued write in one result");

    a_rx_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_ovf |=> r_rx_ovf)
        else $error("receive overflow flag cleared");

    a_write_sets_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == urtb_pkg::KIND_SW_WRITE) |=> r_irq)
        else $error("write left interrupt enable low");

    a_refused_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == urtb_pkg::KIND_SW_WRITE && tx_full)
        |=> (r_tx_ovf && !r_wacc && $stable(r_tx_head)))
        else $error("write into full send ring");

    a_tx_never_full_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tx_we && tx_full))
        else $error("send ring written while full");

endmodule

[rtl/core/urtb_ram.sv]
`timescale 1ns / 1ps

module urtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/sv/urtb_checker.sv]
`timescale 1ns / 1ps

module urtb_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  urtb_pkg::t_kind i_kind,
    input  urtb_pkg::t_byte i_data_in,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  urtb_pkg::t_byte i_data_out,
    input  logic            i_data_valid,
    input  logic            i_write_accepted,
    input  urtb_pkg::t_cnt  i_rx_count,
    input  urtb_pkg::t_cnt  i_tx_count,
    input  logic            i_rx_overflow,
    input  logic            i_tx_overflow,
    input  logic            i_tx_irq_enable,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked,
    output int              o_rx_overruns,
    output int              o_tx_refusals
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        urtb_pkg::t_byte data_out;
        logic            data_valid;
        logic            write_accepted;
        urtb_pkg::t_cnt  rx_count;
        urtb_pkg::t_cnt  tx_count;
        logic            rx_overflow;
        logic            tx_overflow;
        logic            tx_irq_enable;
    } t_ring_result;

    // shadow copy of both rings and their status
    urtb_pkg::t_byte rx_ring [urtb_pkg::DEPTH];
    urtb_pkg::t_byte tx_ring [urtb_pkg::DEPTH];
    int    rx_wr, rx_rd, tx_wr, tx_rd;
    logic  rx_ovf, tx_ovf, irq_en;

    t_ring_result status_q[$];
    t_ring_result exp_r, got_r;
    int           fail_count, checked, rx_overruns, tx_refusals;

    function automatic int ring_next(input int p);
        return (p + 1 >= urtb_pkg::DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int ring_fill(input int head, input int tail);
        return (head - tail + urtb_pkg::DEPTH) % urtb_pkg::DEPTH;
    endfunction

    function automatic void ring_step(input urtb_pkg::t_kind k, input urtb_pkg::t_byte d,
                                      output t_ring_result r);
        int nxt;
        r = '0;
        case (k)
            urtb_pkg::KIND_RX_BYTE: begin
                rx_ring[rx_wr] = d;
                rx_wr = ring_next(rx_wr);
                // overrun: head lands on tail, ring reads as empty
                if (rx_wr == rx_rd) begin
                    rx_ovf = 1'b1;
                    rx_overruns++;
                end
            end
            urtb_pkg::KIND_TX_READY: begin
                if (tx_wr != tx_rd) begin
                    r.data_out   = tx_ring[tx_rd];
                    r.data_valid = 1'b1;
                    tx_rd = ring_next(tx_rd);
                end else begin
                    irq_en = 1'b0;
                end
            end
            urtb_pkg::KIND_SW_READ: begin
                if (rx_wr != rx_rd) begin
                    r.data_out   = rx_ring[rx_rd];
                    r.data_valid = 1'b1;
                    rx_rd = ring_next(rx_rd);
                end
            end
            urtb_pkg::KIND_SW_WRITE: begin
                nxt = ring_next(tx_wr);
                if (nxt == tx_rd) begin
                    tx_ovf = 1'b1;
                    tx_refusals++;
                end else begin
                    tx_ring[tx_wr] = d;
                    tx_wr = nxt;
                    r.write_accepted = 1'b1;
                end
                irq_en = 1'b1;
            end
            urtb_pkg::KIND_RX_FLUSH: begin
                rx_wr = 0;
                rx_rd = 0;
            end
            default: ;
        endcase
        r.rx_count      = urtb_pkg::t_cnt'(ring_fill(rx_wr, rx_rd));
        r.tx_count      = urtb_pkg::t_cnt'(ring_fill(tx_wr, tx_rd));
        r.rx_overflow   = rx_ovf;
        r.tx_overflow   = tx_ovf;
        r.tx_irq_enable = irq_en;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wr = 0;
            rx_rd = 0;
            tx_wr = 0;
            tx_rd = 0;
            rx_ovf = 1'b0;
            tx_ovf = 1'b0;
            irq_en = 1'b0;
            status_q.delete();
        end else begin
            // compare first: a result never belongs to an item taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                got_r = '{i_data_out, i_data_valid, i_write_accepted, i_rx_count,
                          i_tx_count, i_rx_overflow, i_tx_overflow, i_tx_irq_enable};
                if (status_q.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("[%0t] result arrived with nothing expected", $time);
                    fail_count++;
                end else begin
                    exp_r = status_q.pop_front();
                    if (got_r !== exp_r) begin
                        if (fail_count < REPORT_MAX) begin
                            $display("[%0t] result %0d expected/actual: data %h/%h dvalid %b/%b wacc %b/%b",
                                     $time, checked,
                                     exp_r.data_out, got_r.data_out,
                                     exp_r.data_valid, got_r.data_valid,
                                     exp_r.write_accepted, got_r.write_accepted);
                            $display("    rxcnt %0d/%0d txcnt %0d/%0d rxovf %b/%b txovf %b/%b irq %b/%b",
                                     exp_r.rx_count, got_r.rx_count,
                                     exp_r.tx_count, got_r.tx_count,
                                     exp_r.rx_overflow, got_r.rx_overflow,
                                     exp_r.tx_overflow, got_r.tx_overflow,
                                     exp_r.tx_irq_enable, got_r.tx_irq_enable);
                        end
                        fail_count++;
                    end
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ring_step(i_kind, i_data_in, exp_r);
                status_q.push_back(exp_r);
            end
        end
        o_pending     <= status_q.size();
        o_fail_count  <= fail_count;
        o_checked     <= checked;
        o_rx_overruns <= rx_overruns;
        o_tx_refusals <= tx_refusals;
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int   N_ITEMS        = 1800;
    localparam int   PHASE_LEN      = 600;
    localparam int   HOLD_CYCLES    = 80;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   TAIL_CYCLES    = 3;
    // kind codes the block ignores
    localparam urtb_pkg::t_kind KIND_SPARE_FIRST = 3'd5;
    localparam urtb_pkg::t_kind KIND_SPARE_LAST  = 3'd7;

    typedef enum {TRAFFIC_MIX, TRAFFIC_RX_FLOOD, TRAFFIC_TX_FLOOD, TRAFFIC_DRAIN} t_traffic;

    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            i_valid   = 1'b0;
    urtb_pkg::t_kind i_kind    = urtb_pkg::KIND_RX_BYTE;
    urtb_pkg::t_byte i_data_in = '0;
    logic            i_stall   = 1'b0;
    logic            o_stall, o_valid;
    urtb_pkg::t_byte o_data_out;
    logic            o_data_valid, o_write_accepted;
    urtb_pkg::t_cnt  o_rx_count, o_tx_count;
    logic            o_rx_overflow, o_tx_overflow, o_tx_irq_enable;

    int fail_count, pending, checked, rx_overruns, tx_refusals;
    int items_sent = 0;
    int phase      = 0;
    bit hold_req   = 1'b0;

    uart_rx_tx_ring_buffers_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_data_in       (i_data_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_data_out      (o_data_out),
        .o_data_valid    (o_data_valid),
        .o_write_accepted(o_write_accepted),
        .o_rx_count      (o_rx_count),
        .o_tx_count      (o_tx_count),
        .o_rx_overflow   (o_rx_overflow),
        .o_tx_overflow   (o_tx_overflow),
        .o_tx_irq_enable (o_tx_irq_enable)
    );

    urtb_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_kind          (i_kind),
        .i_data_in       (i_data_in),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_data_out      (o_data_out),
        .i_data_valid    (o_data_valid),
        .i_write_accepted(o_write_accepted),
        .i_rx_count      (o_rx_count),
        .i_tx_count      (o_tx_count),
        .i_rx_overflow   (o_rx_overflow),
        .i_tx_overflow   (o_tx_overflow),
        .i_tx_irq_enable (o_tx_irq_enable),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_rx_overruns   (rx_overruns),
        .o_tx_refusals   (tx_refusals)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int sender_idle_pct();
        return (phase == 0) ? 18 : (phase == 1) ? 85 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (phase == 0) ? 85 : (phase == 1) ? 18 : 0;
    endfunction

    // hold the sender off until every expected result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_item(input urtb_pkg::t_kind k, input urtb_pkg::t_byte d);
        if (items_sent == PHASE_LEN || items_sent == 2 * PHASE_LEN) begin
            wait_drained();
            phase++;
            if (phase == 2)
                hold_req = 1'b1;
        end
        while ($urandom_range(99) < sender_idle_pct()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= k;
        i_data_in <= d;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic pick_item(input t_traffic mode, output urtb_pkg::t_kind k,
                             output urtb_pkg::t_byte d);
        int roll;
        roll = $urandom_range(99);
        d    = urtb_pkg::t_byte'($urandom);
        case (mode)
            TRAFFIC_RX_FLOOD: k = (roll < 96) ? urtb_pkg::KIND_RX_BYTE : KIND_SPARE_FIRST;
            TRAFFIC_TX_FLOOD: k = (roll < 96) ? urtb_pkg::KIND_SW_WRITE : KIND_SPARE_LAST;
            TRAFFIC_DRAIN: begin
                if (roll < 45)      k = urtb_pkg::KIND_SW_READ;
                else if (roll < 90) k = urtb_pkg::KIND_TX_READY;
                else if (roll < 95) k = urtb_pkg::KIND_RX_BYTE;
                else                k = urtb_pkg::t_kind'($urandom_range(KIND_SPARE_LAST,
                                                                         KIND_SPARE_FIRST));
            end
            default: begin
                if (roll < 30)      k = urtb_pkg::KIND_RX_BYTE;
                else if (roll < 50) k = urtb_pkg::KIND_TX_READY;
                else if (roll < 70) k = urtb_pkg::KIND_SW_READ;
                else if (roll < 95) k = urtb_pkg::KIND_SW_WRITE;
                else if (roll < 97) k = urtb_pkg::KIND_RX_FLUSH;
                else                k = urtb_pkg::t_kind'($urandom_range(KIND_SPARE_LAST,
                                                                         KIND_SPARE_FIRST));
            end
        endcase
    endtask

    // receiver: random stall per phase, plus one long hold requested by the sender
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < receiver_idle_pct());
        end
    end

    // watchdog: end the run when nothing moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int              seg, seg_len;
        t_traffic        mode;
        urtb_pkg::t_kind k;
        urtb_pkg::t_byte d;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pops, ignored kinds, byte extremes, flush, irq clear
        send_item(urtb_pkg::KIND_SW_READ, 8'h00);
        send_item(urtb_pkg::KIND_TX_READY, 8'hFF);
        send_item(KIND_SPARE_FIRST, 8'hFF);
        send_item(urtb_pkg::KIND_SW_WRITE, 8'hFF);
        send_item(urtb_pkg::KIND_SW_WRITE, 8'h00);
        send_item(urtb_pkg::KIND_TX_READY, 8'h00);
        send_item(urtb_pkg::KIND_RX_BYTE, 8'h00);
        send_item(urtb_pkg::KIND_RX_BYTE, 8'hFF);
        send_item(urtb_pkg::KIND_RX_BYTE, 8'h5A);
        send_item(urtb_pkg::KIND_SW_READ, 8'hFF);
        send_item(urtb_pkg::KIND_RX_FLUSH, 8'hA5);
        send_item(urtb_pkg::KIND_SW_READ, 8'h00);
        send_item(urtb_pkg::KIND_RX_BYTE, 8'hA5);
        send_item(urtb_pkg::KIND_SW_READ, 8'h00);
        send_item(urtb_pkg::KIND_TX_READY, 8'h00);
        send_item(urtb_pkg::KIND_TX_READY, 8'h00);
        send_item(urtb_pkg::t_kind'(KIND_SPARE_FIRST + 3'd1), 8'h3C);
        send_item(KIND_SPARE_LAST, 8'hC3);
        send_item(urtb_pkg::KIND_SW_WRITE, 8'h81);
        send_item(urtb_pkg::KIND_RX_FLUSH, 8'h7E);
        send_item(urtb_pkg::KIND_TX_READY, 8'h00);

        // random: mixed traffic, fill the receive ring past its limit, drain, fill the send ring, then mixed or drain
        seg = 0;
        while (items_sent < N_ITEMS) begin
            case (seg)
                0:       begin mode = TRAFFIC_MIX;      seg_len = 150; end
                1:       begin mode = TRAFFIC_RX_FLOOD; seg_len = $urandom_range(540, 520); end
                2:       begin mode = TRAFFIC_DRAIN;    seg_len = $urandom_range(100, 60); end
                3:       begin mode = TRAFFIC_TX_FLOOD; seg_len = $urandom_range(540, 520); end
                default: begin
                    mode    = ($urandom_range(1) != 0) ? TRAFFIC_MIX : TRAFFIC_DRAIN;
                    seg_len = $urandom_range(120, 20);
                end
            endcase
            repeat (seg_len) begin
                pick_item(mode, k, d);
                send_item(k, d);
            end
            seg++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items across three idle profiles and one long output hold;",
                 items_sent);
        $display("checked %0d results, %0d receive overruns, %0d refused send writes",
                 checked, rx_overruns, tx_refusals);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
